@@ rtl/prqs_pkg.sv @@
// Shared codes, constants and handshake types of the priority ready-queue scheduler.
package prqs_pkg;

  // Operation codes carried on in_tuser.
  localparam logic [1:0] OP_INSERT  = 2'd0;
  localparam logic [1:0] OP_REMOVE  = 2'd1;
  localparam logic [1:0] OP_TICK    = 2'd2;
  localparam logic [1:0] OP_RESCHED = 2'd3;

  // Result status codes carried on out_tuser.
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_DUP    = 2'd1;
  localparam logic [1:0] ST_ABSENT = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_QUANTUM   = 1'b0;
  localparam logic CFG_INIT_PRIO = 1'b1;

  // Q1.8 priority of 1.0 and the floor of the quantum counter.
  localparam logic [8:0]        PRIO_ONE = 9'd256;
  localparam logic signed [8:0] QC_MIN   = 9'sh100;

  // Request to the aging unit.
  typedef struct packed {
    logic              start;
    logic [8:0]        prio;
    logic [7:0]        len;
    logic signed [8:0] qc;
  } age_req_t;

  // Answer of the aging unit.
  typedef struct packed {
    logic       done;
    logic [8:0] prio;
  } age_rsp_t;

endpackage

@@ rtl/prqs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module prqs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/prqs_age.sv @@
// Priority aging unit: one multiply, then a restoring divide at one quotient bit per cycle.
module prqs_age
  import prqs_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  age_req_t req,
  output age_rsp_t rsp
);

  localparam logic [1:0] A_IDLE = 2'd0;
  localparam logic [1:0] A_MUL  = 2'd1;
  localparam logic [1:0] A_LOAD = 2'd2;
  localparam logic [1:0] A_DIV  = 2'd3;
  localparam logic [3:0] LAST_STEP = 4'd8;

  logic [1:0]  st_r, st_nxt;
  logic        done_r, done_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [8:0]  p_r, p_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [7:0]  used_r, used_nxt;
  logic [16:0] prod_r, prod_nxt;
  logic [8:0]  rem_r, rem_nxt;
  logic [8:0]  n_r, n_nxt;

  logic [7:0]  used_c;
  logic [17:0] num;
  logic [8:0]  dvs;
  logic [9:0]  trial;
  logic        ge;

  // Ticks used, clamped to 0..len.
  always_comb begin
    if (req.qc <= 9'sd0) begin
      used_c = req.len;
    end else if (req.qc[7:0] >= req.len) begin
      used_c = 8'd0;
    end else begin
      used_c = req.len - req.qc[7:0];
    end
  end

  assign num   = 18'(prod_r) + 18'({used_r, 8'd0});
  assign dvs   = {len_r, 1'b0};
  assign trial = {rem_r, n_r[8]};
  assign ge    = trial >= {1'b0, dvs};

  always_comb begin
    st_nxt   = st_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    p_nxt    = p_r;
    len_nxt  = len_r;
    used_nxt = used_r;
    prod_nxt = prod_r;
    rem_nxt  = rem_r;
    n_nxt    = n_r;
    case (st_r)
      A_IDLE: begin
        if (req.start) begin
          p_nxt    = req.prio;
          len_nxt  = req.len;
          used_nxt = used_c;
          st_nxt   = A_MUL;
        end
      end
      A_MUL: begin
        prod_nxt = {8'd0, p_r} * {9'd0, len_r};
        st_nxt   = A_LOAD;
      end
      A_LOAD: begin
        // The quotient fits nine bits, so the upper half starts below the divisor.
        rem_nxt = num[17:9];
        n_nxt   = num[8:0];
        cnt_nxt = 4'd0;
        st_nxt  = A_DIV;
      end
      A_DIV: begin
        rem_nxt = ge ? 9'(trial - {1'b0, dvs}) : trial[8:0];
        n_nxt   = {n_r[7:0], ge};
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == LAST_STEP) begin
          done_nxt = 1'b1;
          st_nxt   = A_IDLE;
        end
      end
      default: st_nxt = A_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= A_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    p_r    <= p_nxt;
    len_r  <= len_nxt;
    used_r <= used_nxt;
    prod_r <= prod_nxt;
    rem_r  <= rem_nxt;
    n_r    <= n_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.prio = n_r;

endmodule

@@ rtl/priority_ready_queue_scheduler_top.sv @@
// Top level of the priority ready-queue scheduler: sequencer, queue memories, aging unit and result register.
//
// The scheduler keeps a ready queue of task slots ordered by descending Q1.8 priority, with equal
// priorities in arrival order, and answers every input beat with exactly one result beat that shows
// the selection, the quantum left, the queue length and a status after the operation. Items are
// handled one at a time and in_tready is high only while the sequencer is idle. A timer tick or a
// rejected insert or remove goes straight to the result. An insert walks the queue from its tail
// toward the head through the order and priority memories, moving each entry that sits behind the
// new slot; a remove scans the whole queue from the head and closes the gap. A reschedule that has
// to act ages the current task in a multiply and restoring divide unit (one quotient bit per
// cycle), then removes and reinserts that task if it is still queued and reads the queue head; with
// no task selected it only reads the head. Those memory walks and the divider set the rate. The
// order and priority memories are not cleared after reset and need no clearing pass, so the block
// is ready as soon as reset is released. Configuration beats are taken at any time (cfg_ready is
// always high) but are only meant to arrive while the block is idle.
module priority_ready_queue_scheduler_top
  import prqs_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [3:0] slot, [4] fresh_task, [7:5] zero
  input  logic [1:0]  in_tuser,   // [1:0] opcode
  // Result channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [3:0] selected_slot, [4] selected_valid,
                                  // [13:5] quantum_left, [18:14] queue_count, [23:19] zero
  output logic [1:0]  out_tuser,  // [1:0] status
  // Configuration write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [8:0]  cfg_data
);

  localparam int SW = $clog2(SLOTS);
  localparam int LW = $clog2(SLOTS + 1);

  // Sequencer states.
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_INS_PLD = 4'd1;
  localparam logic [3:0] S_INS_CHK = 4'd2;
  localparam logic [3:0] S_INS_ORD = 4'd3;
  localparam logic [3:0] S_INS_CMP = 4'd4;
  localparam logic [3:0] S_RM_RD   = 4'd5;
  localparam logic [3:0] S_RM_CHK  = 4'd6;
  localparam logic [3:0] S_AGE_RD  = 4'd7;
  localparam logic [3:0] S_AGE_WT  = 4'd8;
  localparam logic [3:0] S_PICK    = 4'd9;
  localparam logic [3:0] S_PICK_RD = 4'd10;
  localparam logic [3:0] S_DONE    = 4'd11;

  // Control state.
  logic [3:0]        state_r, state_nxt;
  logic [LW-1:0]     len_r, len_nxt;
  logic [SLOTS-1:0]  mask_r, mask_nxt;
  logic [SW-1:0]     cur_r, cur_nxt;
  logic              cv_r, cv_nxt;
  logic signed [8:0] qc_r, qc_nxt;
  logic [7:0]        ql_r, ql_nxt;
  logic [8:0]        ip_r, ip_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              found_r, found_nxt;
  logic              resched_r, resched_nxt;

  // Working payload.
  logic [SW-1:0]     s_r, s_nxt;
  logic [8:0]        p_r, p_nxt;
  logic [SW-1:0]     d_r, d_nxt;
  logic [LW-1:0]     j_r, j_nxt;
  logic [1:0]        status_r, status_nxt;
  logic [18:0]       out_data_r, out_data_nxt;
  logic [1:0]        out_status_r, out_status_nxt;

  // Memory ports.
  logic              ord_we, pri_we;
  logic [SW-1:0]     ord_waddr, ord_raddr, pri_waddr, pri_raddr;
  logic [SW-1:0]     ord_wdata, ord_rdata;
  logic [8:0]        pri_wdata, pri_rdata;

  age_req_t          age_req;
  age_rsp_t          age_rsp;
  logic              age_start;

  logic [1:0]        in_op;
  logic [SW-1:0]     slot_idx;
  logic              slot_ok;
  logic              in_fresh;
  logic [8:0]        init_sat;
  logic [7:0]        eff_len;
  logic [LW-1:0]     j_dec, j_inc;

  assign in_op     = in_tuser;
  assign slot_idx  = SW'(in_tdata[3:0]);
  assign slot_ok   = int'(in_tdata[3:0]) < SLOTS;
  assign in_fresh  = in_tdata[4];
  assign init_sat  = (ip_r > PRIO_ONE) ? PRIO_ONE : ip_r;
  assign eff_len   = (ql_r == 8'd0) ? 8'd1 : ql_r;
  assign j_dec     = j_r - LW'(1);
  assign j_inc     = j_r + LW'(1);
  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;

  assign age_req = '{start: age_start, prio: pri_rdata, len: eff_len, qc: qc_r};

  always_comb begin
    state_nxt      = state_r;
    len_nxt        = len_r;
    mask_nxt       = mask_r;
    cur_nxt        = cur_r;
    cv_nxt         = cv_r;
    qc_nxt         = qc_r;
    ql_nxt         = ql_r;
    ip_nxt         = ip_r;
    out_valid_nxt  = out_valid_r & ~out_tready;
    found_nxt      = found_r;
    resched_nxt    = resched_r;
    s_nxt          = s_r;
    p_nxt          = p_r;
    d_nxt          = d_r;
    j_nxt          = j_r;
    status_nxt     = status_r;
    out_data_nxt   = out_data_r;
    out_status_nxt = out_status_r;
    ord_we         = 1'b0;
    ord_waddr      = j_r[SW-1:0];
    ord_wdata      = s_r;
    ord_raddr      = '0;
    pri_we         = 1'b0;
    pri_waddr      = s_r;
    pri_wdata      = p_r;
    pri_raddr      = cur_r;
    age_start      = 1'b0;

    if (cfg_valid) begin
      if (cfg_index == CFG_QUANTUM) begin
        ql_nxt = cfg_data[7:0];
      end else begin
        ip_nxt = cfg_data;
      end
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          s_nxt       = slot_idx;
          status_nxt  = ST_OK;
          resched_nxt = 1'b0;
          found_nxt   = 1'b0;
          j_nxt       = len_r;
          case (in_op)
            OP_INSERT: begin
              if (!slot_ok || mask_r[slot_idx]) begin
                status_nxt = ST_DUP;
                state_nxt  = S_DONE;
              end else if (in_fresh) begin
                pri_we    = 1'b1;
                pri_waddr = slot_idx;
                pri_wdata = init_sat;
                p_nxt     = init_sat;
                state_nxt = S_INS_CHK;
              end else begin
                pri_raddr = slot_idx;
                state_nxt = S_INS_PLD;
              end
            end
            OP_REMOVE: begin
              if (!(slot_ok && mask_r[slot_idx])) begin
                status_nxt = ST_ABSENT;
                state_nxt  = S_DONE;
              end else begin
                j_nxt     = '0;
                state_nxt = S_RM_RD;
              end
            end
            OP_TICK: begin
              if (qc_r != QC_MIN) begin
                qc_nxt = qc_r - 9'sd1;
              end
              state_nxt = S_DONE;
            end
            default: begin
              resched_nxt = 1'b1;
              if (cv_r && mask_r[cur_r] && qc_r > 9'sd0) begin
                state_nxt = S_DONE;
              end else if (cv_r) begin
                pri_raddr = cur_r;
                state_nxt = S_AGE_RD;
              end else begin
                state_nxt = S_PICK;
              end
            end
          endcase
        end
      end
      S_INS_PLD: begin
        p_nxt     = pri_rdata;
        state_nxt = S_INS_CHK;
      end
      S_INS_CHK: begin
        ord_raddr = j_dec[SW-1:0];
        if (j_r == '0) begin
          ord_we           = 1'b1;
          ord_waddr        = '0;
          ord_wdata        = s_r;
          len_nxt          = len_r + LW'(1);
          mask_nxt[s_r]    = 1'b1;
          state_nxt        = resched_r ? S_PICK : S_DONE;
        end else begin
          state_nxt = S_INS_ORD;
        end
      end
      S_INS_ORD: begin
        d_nxt     = ord_rdata;
        pri_raddr = ord_rdata;
        state_nxt = S_INS_CMP;
      end
      S_INS_CMP: begin
        ord_we    = 1'b1;
        ord_waddr = j_r[SW-1:0];
        if (pri_rdata >= p_r) begin
          // Everything ahead is at least as urgent: the new slot lands here.
          ord_wdata     = s_r;
          len_nxt       = len_r + LW'(1);
          mask_nxt[s_r] = 1'b1;
          state_nxt     = resched_r ? S_PICK : S_DONE;
        end else begin
          ord_wdata = d_r;
          j_nxt     = j_dec;
          state_nxt = S_INS_CHK;
        end
      end
      S_RM_RD: begin
        ord_raddr = j_r[SW-1:0];
        state_nxt = S_RM_CHK;
      end
      S_RM_CHK: begin
        if (found_r) begin
          ord_we    = 1'b1;
          ord_waddr = j_dec[SW-1:0];
          ord_wdata = ord_rdata;
        end
        if (ord_rdata == s_r) begin
          found_nxt = 1'b1;
        end
        j_nxt = j_inc;
        if (j_inc == len_r) begin
          len_nxt       = len_r - LW'(1);
          mask_nxt[s_r] = 1'b0;
          if (resched_r) begin
            j_nxt     = len_r - LW'(1);
            state_nxt = S_INS_CHK;
          end else begin
            state_nxt = S_DONE;
          end
        end else begin
          state_nxt = S_RM_RD;
        end
      end
      S_AGE_RD: begin
        age_start = 1'b1;
        state_nxt = S_AGE_WT;
      end
      S_AGE_WT: begin
        if (age_rsp.done) begin
          pri_we    = 1'b1;
          pri_waddr = cur_r;
          pri_wdata = age_rsp.prio;
          p_nxt     = age_rsp.prio;
          s_nxt     = cur_r;
          if (mask_r[cur_r]) begin
            j_nxt     = '0;
            found_nxt = 1'b0;
            state_nxt = S_RM_RD;
          end else begin
            state_nxt = S_PICK;
          end
        end
      end
      S_PICK: begin
        ord_raddr = '0;
        if (len_r == '0) begin
          cv_nxt    = 1'b0;
          cur_nxt   = '0;
          qc_nxt    = 9'sd0;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_PICK_RD;
        end
      end
      S_PICK_RD: begin
        cur_nxt = ord_rdata;
        cv_nxt  = 1'b1;
        if (!cv_r || cur_r != ord_rdata) begin
          qc_nxt = $signed({1'b0, eff_len});
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_data_nxt   = {5'(len_r), qc_r, cv_r, 4'(cur_r)};
          out_status_nxt = status_r;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= '0;
      mask_r      <= '0;
      cur_r       <= '0;
      cv_r        <= 1'b0;
      qc_r        <= 9'sd0;
      ql_r        <= 8'd10;
      ip_r        <= 9'd128;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
      resched_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      mask_r      <= mask_nxt;
      cur_r       <= cur_nxt;
      cv_r        <= cv_nxt;
      qc_r        <= qc_nxt;
      ql_r        <= ql_nxt;
      ip_r        <= ip_nxt;
      out_valid_r <= out_valid_nxt;
      found_r     <= found_nxt;
      resched_r   <= resched_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s_r          <= s_nxt;
    p_r          <= p_nxt;
    d_r          <= d_nxt;
    j_r          <= j_nxt;
    status_r     <= status_nxt;
    out_data_r   <= out_data_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_data_r};
  assign out_tuser  = out_status_r;

  // Queue order: slot numbers from head to tail.
  prqs_ram #(
    .WIDTH(SW),
    .DEPTH(SLOTS)
  ) u_order (
    .clk  (clk),
    .we   (ord_we),
    .waddr(ord_waddr),
    .wdata(ord_wdata),
    .raddr(ord_raddr),
    .rdata(ord_rdata)
  );

  // Priority of each slot.
  prqs_ram #(
    .WIDTH(9),
    .DEPTH(SLOTS)
  ) u_prio (
    .clk  (clk),
    .we   (pri_we),
    .waddr(pri_waddr),
    .wdata(pri_wdata),
    .raddr(pri_raddr),
    .rdata(pri_rdata)
  );

  prqs_age u_age (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (age_req),
    .rsp  (age_rsp)
  );

  // The queued mask and the queue length must always agree.
  assert property (@(posedge clk) disable iff (!rst_n)
    $countones(mask_r) == int'(len_r))
    else $error("queued mask and queue length disagree");

  // With no task selected the current slot reads as zero.
  assert property (@(posedge clk) disable iff (!rst_n)
    !cv_r |-> cur_r == '0)
    else $error("current slot nonzero while no task is selected");

  // Reading the queue head always leaves a task selected.
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PICK_RD |=> cv_r)
    else $error("pick from a nonempty queue left no task selected");

  // An aged priority never exceeds 383, the average of the largest nine-bit value and one.
  assert property (@(posedge clk) disable iff (!rst_n)
    age_rsp.done |-> age_rsp.prio <= 9'd383)
    else $error("aged priority out of range");

  // A new result waits in the done state until the pending one has been taken.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready && state_r == S_DONE) |=> state_r == S_DONE)
    else $error("result register overwritten before it was taken");

endmodule

@@ verif/tb.sv @@
// Self-checking testbench for the priority ready-queue scheduler: stream driver, monitor and predictor.
`timescale 1ns / 100ps

module tb
  import prqs_pkg::*;
();

  localparam int SLOTS         = 16;
  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int SETTLE_CYCLES = 120;
  localparam int PHASES        = 7;

  // One operation as presented on the input stream.
  typedef struct packed {
    logic [1:0] op;
    logic [3:0] slot;
    logic       fresh;
  } sched_op_t;

  // What the scheduler reports after one operation.
  typedef struct packed {
    logic [3:0]        slot;
    logic              valid;
    logic signed [8:0] qleft;
    logic [4:0]        qcount;
    logic [1:0]        status;
  } sched_view_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [8:0]  cfg_data = '0;

  priority_ready_queue_scheduler_top #(.SLOTS(SLOTS)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Scheduler image kept by the testbench.
  logic [7:0]       cfg_quantum;
  logic [8:0]       cfg_init_prio;
  logic [3:0]       rq_order [SLOTS];
  int               rq_len;
  logic [SLOTS-1:0] rq_mask;
  logic [8:0]       slot_prio [SLOTS];
  bit               prio_known [SLOTS];
  logic [3:0]       run_slot;
  bit               run_valid;
  int               quantum_ctr;

  sched_op_t   ops_pending [$];
  sched_view_t views_due [$];
  sched_op_t   cur_op;

  int ops_planned;
  int ops_accepted;
  int views_checked;
  int mismatches;
  int acted_rescheds;
  int op_tally [4];
  int settings_used;
  int cycle_cnt;

  int send_wait;
  bit send_calm;
  int recv_wait;
  bit recv_calm;

  function automatic void rq_drop(input logic [3:0] s);
    int i;
    int j;
    bit hit;
    hit = 1'b0;
    for (i = 0; i < rq_len; i++) begin
      if (!hit && rq_order[i] == s) begin
        hit = 1'b1;
        for (j = i; j + 1 < rq_len; j++) rq_order[j] = rq_order[j + 1];
      end
    end
    if (hit) begin
      rq_len--;
      rq_mask[s] = 1'b0;
    end
  endfunction

  // New entry goes behind every entry of equal or higher priority.
  function automatic void rq_place(input logic [3:0] s);
    int pos;
    int j;
    pos = 0;
    if (rq_len >= SLOTS) return;
    while (pos < rq_len && slot_prio[rq_order[pos]] >= slot_prio[s]) pos++;
    for (j = rq_len; j > pos; j--) rq_order[j] = rq_order[j - 1];
    rq_order[pos] = s;
    rq_len++;
    rq_mask[s] = 1'b1;
  endfunction

  function automatic int quantum_eff();
    return (cfg_quantum == 0) ? 1 : int'(cfg_quantum);
  endfunction

  // p' = (p * L + used * 1.0) / (2 * L), truncated once.
  function automatic void age_running();
    int len;
    int used;
    int p;
    len = quantum_eff();
    p = int'(slot_prio[run_slot]);
    if (quantum_ctr <= 0) used = len;
    else if (quantum_ctr >= len) used = 0;
    else used = len - quantum_ctr;
    slot_prio[run_slot] = 9'((p * len + used * int'(PRIO_ONE)) / (2 * len));
  endfunction

  function automatic void reschedule();
    logic [3:0] prev;
    bit prev_valid;
    prev = run_slot;
    prev_valid = run_valid;
    if (run_valid && rq_mask[run_slot] && quantum_ctr > 0) return;
    acted_rescheds++;
    if (run_valid) begin
      age_running();
      if (rq_mask[run_slot]) begin
        rq_drop(run_slot);
        rq_place(run_slot);
      end
    end
    if (rq_len == 0) begin
      run_valid = 1'b0;
      run_slot = '0;
      quantum_ctr = 0;
      return;
    end
    run_slot = rq_order[0];
    run_valid = 1'b1;
    if (!prev_valid || prev != run_slot) quantum_ctr = quantum_eff();
  endfunction

  function automatic sched_view_t step_scheduler(input sched_op_t it);
    sched_view_t v;
    v.status = ST_OK;
    case (it.op)
      OP_INSERT: begin
        if (rq_mask[it.slot]) begin
          v.status = ST_DUP;
        end else begin
          if (it.fresh) begin
            slot_prio[it.slot] = (cfg_init_prio > PRIO_ONE) ? PRIO_ONE : cfg_init_prio;
            prio_known[it.slot] = 1'b1;
          end
          rq_place(it.slot);
        end
      end
      OP_REMOVE: begin
        if (!rq_mask[it.slot]) v.status = ST_ABSENT;
        else rq_drop(it.slot);
      end
      OP_TICK: begin
        if (quantum_ctr > int'(QC_MIN)) quantum_ctr--;
      end
      default: begin
        reschedule();
      end
    endcase
    v.slot   = run_valid ? run_slot : 4'd0;
    v.valid  = run_valid;
    v.qleft  = 9'(quantum_ctr);
    v.qcount = 5'(rq_len);
    return v;
  endfunction

  // Input driver: one operation at a time, with a random gap after each beat.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      send_wait = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        views_due.push_back(step_scheduler(cur_op));
        ops_accepted++;
        op_tally[cur_op.op]++;
      end
      if (in_tvalid && !in_tready) begin
        // Hold the beat until it is taken.
      end else if (send_wait > 0) begin
        in_tvalid <= 1'b0;
        send_wait--;
      end else if (ops_pending.size() != 0) begin
        cur_op = ops_pending.pop_front();
        // A slot whose priority was never set must get one on insert.
        if (cur_op.op == OP_INSERT && !rq_mask[cur_op.slot] && !prio_known[cur_op.slot])
          cur_op.fresh = 1'b1;
        in_tvalid <= 1'b1;
        in_tdata  <= {3'b000, cur_op.fresh, cur_op.slot};
        in_tuser  <= cur_op.op;
        if ($urandom_range(0, 29) == 0) send_calm = !send_calm;
        send_wait = send_calm ? 0 : $urandom_range(0, 14);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result monitor with random back-pressure.
  always @(posedge clk) begin : monitor
    sched_view_t want;
    if (!rst_n) begin
      out_tready <= 1'b1;
      recv_wait = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        views_checked++;
        if (views_due.size() == 0) begin
          $error("result beat with no operation outstanding: tdata %h tuser %h",
                 out_tdata, out_tuser);
          mismatches++;
        end else begin
          want = views_due.pop_front();
          if (out_tdata[3:0] !== want.slot) begin
            $error("selected_slot: expected %0d, got %0d", want.slot, out_tdata[3:0]);
            mismatches++;
          end
          if (out_tdata[4] !== want.valid) begin
            $error("selected_valid: expected %0d, got %0d", want.valid, out_tdata[4]);
            mismatches++;
          end
          if (out_tdata[13:5] !== want.qleft) begin
            $error("quantum_left: expected %0d, got %0d", want.qleft,
                   $signed(out_tdata[13:5]));
            mismatches++;
          end
          if (out_tdata[18:14] !== want.qcount) begin
            $error("queue_count: expected %0d, got %0d", want.qcount, out_tdata[18:14]);
            mismatches++;
          end
          if (out_tuser !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_tuser);
            mismatches++;
          end
        end
        if ($urandom_range(0, 29) == 0) recv_calm = !recv_calm;
        recv_wait = recv_calm ? 0 : $urandom_range(0, 14);
        out_tready <= (recv_wait == 0);
      end else if (!out_tready) begin
        if (recv_wait <= 1) out_tready <= 1'b1;
        if (recv_wait > 0) recv_wait--;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("** priority_ready_queue_scheduler_top: FAILED **");
      $finish;
    end
  end

  task automatic add_op(input logic [1:0] op, input logic [3:0] slot, input logic fresh);
    sched_op_t it;
    it.op = op;
    it.slot = slot;
    it.fresh = fresh;
    ops_pending.push_back(it);
    ops_planned++;
  endtask

  task automatic add_filler(input logic [1:0] op);
    add_op(op, 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
  endtask

  // Registers change only here, with the scheduler idle.
  task automatic write_register(input logic idx, input logic [8:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_QUANTUM) cfg_quantum = val[7:0];
    else cfg_init_prio = val;
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (ops_accepted != ops_planned || views_due.size() != 0) @(posedge clk);
  endtask

  // Hand-picked sequence with quantum 3 and fresh priority 1.0.
  task automatic plan_directed();
    add_op(OP_RESCHED, 4'd0, 1'b0);   // nothing to pick from
    add_op(OP_TICK, 4'd0, 1'b0);      // idle tick still counts down
    add_op(OP_REMOVE, 4'd5, 1'b0);    // absent slot
    add_op(OP_INSERT, 4'd0, 1'b1);
    add_op(OP_INSERT, 4'd15, 1'b1);   // equal priority lands behind slot 0
    add_op(OP_INSERT, 4'd0, 1'b1);    // already queued
    add_op(OP_RESCHED, 4'd0, 1'b0);   // first pick, quantum loaded
    add_op(OP_RESCHED, 4'd0, 1'b0);   // quantum left, no action
    repeat (3) add_op(OP_TICK, 4'd0, 1'b0);
    add_op(OP_RESCHED, 4'd0, 1'b0);   // aged, re-sorted behind slot 15
    add_op(OP_TICK, 4'd0, 1'b0);
    add_op(OP_RESCHED, 4'd0, 1'b0);
    add_op(OP_REMOVE, 4'd15, 1'b0);   // running task leaves the queue
    add_op(OP_RESCHED, 4'd15, 1'b1);
    add_op(OP_INSERT, 4'd7, 1'b1);
    add_op(OP_INSERT, 4'd15, 1'b0);   // keeps its aged priority
    add_op(OP_RESCHED, 4'd0, 1'b0);   // quantum left, no action
    add_op(OP_REMOVE, 4'd0, 1'b0);
    add_op(OP_REMOVE, 4'd15, 1'b0);
    add_op(OP_REMOVE, 4'd7, 1'b1);
    add_op(OP_RESCHED, 4'd0, 1'b0);   // queue emptied, goes idle
  endtask

  // Mostly insert / run out the quantum / reschedule episodes, the rest single random ops.
  task automatic plan_random(input int budget, input int qlen);
    int first;
    int n;
    int cap;
    first = ops_planned;
    while (ops_planned - first < budget) begin
      if ($urandom_range(0, 99) < 70) begin
        n = $urandom_range(1, 3);
        repeat (n) add_filler(OP_INSERT);
        add_filler(OP_RESCHED);
        cap = (qlen < 12) ? qlen + 1 : 12;
        n = ($urandom_range(0, 9) == 0) ? qlen + $urandom_range(0, 2) : $urandom_range(0, cap);
        repeat (n) add_filler(OP_TICK);
        add_filler(OP_RESCHED);
        n = $urandom_range(0, 3);
        repeat (n) add_filler(OP_REMOVE);
        if ($urandom_range(0, 1) == 1) add_filler(OP_RESCHED);
      end else begin
        add_filler(2'($urandom_range(0, 3)));
      end
    end
  endtask

  initial begin
    int ph;
    int qlen;
    int iprio;
    cfg_quantum   = 8'd10;
    cfg_init_prio = 9'd128;
    rq_len        = 0;
    rq_mask       = '0;
    run_slot      = '0;
    run_valid     = 1'b0;
    quantum_ctr   = 0;
    for (int i = 0; i < SLOTS; i++) begin
      rq_order[i]   = '0;
      slot_prio[i]  = '0;
      prio_known[i] = 1'b0;
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin qlen = 3;   iprio = 256; end
        1: begin qlen = 1;   iprio = 0;   end
        2: begin qlen = 255; iprio = 128; end
        3: begin qlen = 10;  iprio = 37;  end
        5: begin qlen = 2;   iprio = 255; end
        default: begin
          qlen = $urandom_range(1, 255);
          iprio = $urandom_range(0, 256);
        end
      endcase
      write_register(CFG_QUANTUM, 9'(qlen));
      write_register(CFG_INIT_PRIO, 9'(iprio));
      settings_used++;
      if (ph == 0) plan_directed();
      // Long tick run drives the quantum counter into its floor.
      if (ph == 1) repeat (262) add_filler(OP_TICK);
      plan_random(190, qlen);
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (views_due.size() != 0) begin
      $error("%0d expected results never arrived", views_due.size());
      mismatches++;
    end

    $display("Ran %0d operations (insert %0d, remove %0d, tick %0d, reschedule %0d) over %0d",
             ops_accepted, op_tally[OP_INSERT], op_tally[OP_REMOVE], op_tally[OP_TICK],
             op_tally[OP_RESCHED], settings_used);
    $display("register settings; %0d results checked, %0d reschedules aged or switched a task.",
             views_checked, acted_rescheds);
    if (mismatches == 0) begin
      $display("** priority_ready_queue_scheduler_top: PASSED **");
    end else begin
      $display("** priority_ready_queue_scheduler_top: FAILED **");
    end
    $finish;
  end

endmodule
